// ----- hw/rtl/size_class_free_list_allocator_assert.svh -----
// Assertion macros for the size-class free-list allocator.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SCFLA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// next-cycle implication, disabled in reset
`define SCFLA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// ----- hw/rtl/scfla_pkg.sv -----
// Types, codes and size-class helpers for the size-class free-list allocator.
package scfla_pkg;

  localparam int unsigned ARENA_LINES_DEF = 16384;
  localparam int unsigned CLASS_COUNT_DEF = 192;
  localparam int unsigned LINE_BYTES      = 64;
  localparam int unsigned SMALL_LIMIT     = 8192;
  localparam int unsigned POW2_CLASSES    = 64;

  localparam int unsigned SIZE_W  = 21;
  localparam int unsigned ALIGN_W = 13;
  localparam int unsigned ADDR_W  = 20;
  localparam int unsigned CLASS_W = 8;
  localparam int unsigned BYTES_W = 22;

  localparam logic [SIZE_W-1:0] ARENA_LIMIT_RST = 21'd1048576;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_REARM = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_ALIGN = 2'd1;
  localparam logic [1:0] STAT_NO_SPACE  = 2'd2;
  localparam logic [1:0] STAT_SIZE_ERR  = 2'd3;

  localparam logic CFG_LOW_WATER   = 1'b0;
  localparam logic CFG_ARENA_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [SIZE_W-1:0]  request_size;
    logic [ALIGN_W-1:0] alignment;
    logic [ADDR_W-1:0]  block_address;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted_address;
    logic [SIZE_W-1:0] granted_size;
    logic              low_memory_event;
  } alloc_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_LINK
  } state_t;

  function automatic logic [CLASS_W-1:0] class_of(logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] m;
    logic [SIZE_W-1:0] m1;
    logic [4:0]        msb;
    m   = (n == '0) ? SIZE_W'(1) : n;
    m1  = m - SIZE_W'(1);
    msb = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (m1[i]) msb = 5'(i);
    end
    if (m <= SIZE_W'(SMALL_LIMIT)) begin
      return CLASS_W'(POW2_CLASSES) + CLASS_W'(m1 >> 6);
    end
    return CLASS_W'(msb) + CLASS_W'(1);
  endfunction

  function automatic logic [BYTES_W-1:0] class_bytes(logic [CLASS_W-1:0] k);
    logic [CLASS_W-1:0] steps;
    steps = k - CLASS_W'(POW2_CLASSES - 1);
    if (k < CLASS_W'(POW2_CLASSES)) begin
      return BYTES_W'(1) << k;
    end
    return BYTES_W'({steps, 6'b0});
  endfunction

endpackage

// ----- hw/rtl/size_class_free_list_allocator.sv -----
// Size-class free-list allocator: per-class LIFO lists in RAM plus a bump arena.
// out_valid is registered: it rises as the FSM leaves ST_HEAD, or ST_LINK when an allocation pops a list.
// Requests are taken only in ST_IDLE; busy holds off the next one through ST_HEAD (head RAM read)
//   and, on a free-list pop, ST_LINK (link RAM read).
// The receiver cannot stall; each result is on out_rsp for one cycle with out_valid.
// Reset (sync, active low): all free lists empty, bump offset 0, event armed,
//   registers at defaults; the link RAM is not cleared and no request is held off.
`include "size_class_free_list_allocator_assert.svh"

module size_class_free_list_allocator
  import scfla_pkg::*;
#(
  parameter int unsigned ARENA_LINES = ARENA_LINES_DEF,
  parameter int unsigned CLASS_COUNT = CLASS_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  alloc_req_t        in_req,
  output logic              out_valid,
  output alloc_rsp_t        out_rsp,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int unsigned LW          = $clog2(ARENA_LINES);
  localparam int unsigned CW          = $clog2(CLASS_COUNT);
  localparam int unsigned ARENA_BYTES = ARENA_LINES * LINE_BYTES;

  state_t state_r, state_nxt;

  logic [LW-1:0] head_mem_r [CLASS_COUNT];
  logic [LW:0]   link_mem_r [ARENA_LINES];
  logic [CLASS_COUNT-1:0] head_vld_r;

  logic [1:0]         mode_r;
  logic [CW-1:0]      cls_idx_r;
  logic               cls_ok_r;
  logic [BYTES_W-1:0] bytes_r;
  logic               align_bad_r;
  logic               size_match_r;
  logic [LW-1:0]      fline_r;
  logic               fline_ok_r;
  logic [LW-1:0]      head_rd_r;
  logic [LW:0]        link_rd_r;

  logic [SIZE_W-1:0] bump_r, bump_nxt;
  logic              sent_r, sent_nxt;
  logic [SIZE_W-1:0] lwm_r;
  logic [SIZE_W-1:0] limit_r;
  logic              out_valid_r, out_valid_nxt;
  alloc_rsp_t        out_rsp_r, rsp_nxt;

  logic               acc;
  logic [CLASS_W-1:0] in_cls;
  logic [BYTES_W-1:0] in_bytes;
  logic [ADDR_W-7:0]  in_line;
  logic               head_vld;
  logic [SIZE_W-1:0]  lim_eff;
  logic [SIZE_W+1:0]  bump_sum;
  logic               bump_fit;
  logic [SIZE_W-1:0]  new_off;
  logic [SIZE_W-1:0]  remain;
  logic               head_we;
  logic [LW-1:0]      head_wd;
  logic               vld_wd;
  logic               link_we;
  logic               link_re;
  logic               grant_zero;

  assign acc       = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign in_cls   = class_of(in_req.request_size);
  assign in_bytes = class_bytes(in_cls);
  assign in_line  = in_req.block_address[ADDR_W-1:6];

  assign head_vld = head_vld_r[cls_idx_r];
  assign lim_eff  = (27'(limit_r) > 27'(ARENA_BYTES)) ? SIZE_W'(ARENA_BYTES) : limit_r;
  assign bump_sum = (SIZE_W+2)'(bump_r) + (SIZE_W+2)'(bytes_r);
  assign bump_fit = (bump_sum <= (SIZE_W+2)'(lim_eff));
  assign new_off  = bump_sum[SIZE_W-1:0];
  assign remain   = lim_eff - new_off;

  assign grant_zero = (out_rsp_r.granted_address == '0) && (out_rsp_r.granted_size == '0);

  // request decode, registered at accept
  always_ff @(posedge clk) begin
    if (acc) begin
      mode_r       <= in_req.mode;
      cls_idx_r    <= in_cls[CW-1:0];
      cls_ok_r     <= ({1'b0, in_cls} < (CLASS_W+1)'(CLASS_COUNT));
      bytes_r      <= in_bytes;
      align_bad_r  <= (in_req.alignment > ALIGN_W'(LINE_BYTES));
      size_match_r <= (in_bytes == BYTES_W'(in_req.request_size));
      fline_r      <= LW'(in_line);
      fline_ok_r   <= (32'(in_line) < ARENA_LINES);
    end
  end

  // head RAM; reads issue at accept, so the previous write has always landed
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem_r[cls_idx_r] <= head_wd;
    end
    if (acc) begin
      head_rd_r <= head_mem_r[in_cls[CW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= '0;
    end else if (head_we) begin
      head_vld_r[cls_idx_r] <= vld_wd;
    end
  end

  // link RAM: push writes in ST_HEAD, pop reads in ST_HEAD, never both
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem_r[fline_r] <= {head_vld, head_rd_r};
    end
    if (link_re) begin
      link_rd_r <= link_mem_r[head_rd_r];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    rsp_nxt       = '0;
    bump_nxt      = bump_r;
    sent_nxt      = sent_r;
    head_we       = 1'b0;
    head_wd       = fline_r;
    vld_wd        = 1'b1;
    link_we       = 1'b0;
    link_re       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) state_nxt = ST_HEAD;
      end
      ST_HEAD: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        unique case (mode_r)
          MODE_ALLOC: begin
            priority if (align_bad_r) begin
              rsp_nxt.status = STAT_BAD_ALIGN;
            end else if (!cls_ok_r) begin
              rsp_nxt.status = STAT_NO_SPACE;
            end else if (head_vld) begin
              link_re       = 1'b1;
              state_nxt     = ST_LINK;
              out_valid_nxt = 1'b0;
            end else if (!bump_fit) begin
              rsp_nxt.status = STAT_NO_SPACE;
            end else begin
              rsp_nxt.granted_address = ADDR_W'(bump_r);
              rsp_nxt.granted_size    = SIZE_W'(bytes_r);
              bump_nxt                = new_off;
              if ((remain < lwm_r) && !sent_r) begin
                sent_nxt                 = 1'b1;
                rsp_nxt.low_memory_event = 1'b1;
              end
            end
          end
          MODE_FREE: begin
            if (!cls_ok_r || !size_match_r) begin
              rsp_nxt.status = STAT_SIZE_ERR;
            end else if (fline_ok_r) begin
              link_we = 1'b1;
              head_we = 1'b1;
            end
          end
          MODE_REARM: begin
            sent_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
      ST_LINK: begin
        state_nxt               = ST_IDLE;
        out_valid_nxt           = 1'b1;
        head_we                 = 1'b1;
        head_wd                 = link_rd_r[LW-1:0];
        vld_wd                  = link_rd_r[LW];
        rsp_nxt.granted_address = ADDR_W'({head_rd_r, 6'b0});
        rsp_nxt.granted_size    = SIZE_W'(bytes_r);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bump_r      <= '0;
      sent_r      <= 1'b0;
      out_valid_r <= 1'b0;
      lwm_r       <= '0;
      limit_r     <= ARENA_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      bump_r      <= bump_nxt;
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOW_WATER:   lwm_r   <= cfg_data;
          CFG_ARENA_LIMIT: limit_r <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= rsp_nxt;
  end

  `SCFLA_ASSERT_IMP(a_strobe_when_idle, out_valid_r, state_r == ST_IDLE)
  `SCFLA_ASSERT_NXT(a_accept_reads_head, acc, state_r == ST_HEAD)
  `SCFLA_ASSERT_IMP(a_link_after_head, state_r == ST_LINK, $past(state_r) == ST_HEAD)
  `SCFLA_ASSERT_IMP(a_fail_no_grant, out_valid_r && (out_rsp_r.status != STAT_OK), grant_zero)
  `SCFLA_ASSERT_IMP(a_event_one_shot, out_valid_r && out_rsp_r.low_memory_event, sent_r && !$past(sent_r))

endmodule
